### design/sms_pkg.sv
// Shared types and constants for the sorted mark set core.
`default_nettype none

package sms_pkg;

    // Row width and default mark capacity
    localparam int ROW_BITS      = 16;
    localparam int MAX_MARKS_DEF = 64;

    // Configuration register indexes
    localparam int CFG_IDX_BITS  = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_ROW = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_ROW   = 1'b1;

    // Register reset values
    localparam logic [ROW_BITS-1:0] START_ROW_RST = '0;
    localparam logic [ROW_BITS-1:0] END_ROW_RST   = '1;

    // Operation codes
    typedef enum logic [1:0] {
        MODE_TOGGLE = 2'd0,
        MODE_HAS    = 2'd1,
        MODE_NEXT   = 2'd2,
        MODE_PREV   = 2'd3
    } t_mode;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;
    } t_ctrl_status;

endpackage

`default_nettype wire

### design/sms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/sms_ctrl.sv
// Controller state machine: accept, scan the store, finish the item.
`default_nettype none

module sms_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output      logic              o_busy,
    output      sms_pkg::t_ctrl_cmd o_cmd,
    input  wire sms_pkg::t_ctrl_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands to the datapath
    assign o_busy       = (r_state != S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_start;
    assign o_cmd.scan   = (r_state == S_SCAN);
    assign o_cmd.finish = (r_state == S_FINISH);

endmodule

`default_nettype wire

### design/sms_datapath.sv
// Datapath: mark store, linear scan with compare, update and result registers.
`default_nettype none

module sms_datapath #(
    parameter int MAX_MARKS = sms_pkg::MAX_MARKS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire sms_pkg::t_ctrl_cmd                i_cmd,
    output      sms_pkg::t_ctrl_status             o_status,
    input  wire logic [1:0]                        i_mode,
    input  wire logic [sms_pkg::ROW_BITS-1:0]      i_row,
    input  wire logic                              i_cfg_we,
    input  wire logic [sms_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [sms_pkg::ROW_BITS-1:0]      i_cfg_data,
    output      logic                              o_strobe,
    output      logic                              o_is_marked,
    output      logic [sms_pkg::ROW_BITS-1:0]      o_mark_row,
    output      logic                              o_result_status
);

    localparam int AW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
    localparam int CW = $clog2(MAX_MARKS + 1);
    localparam int RW = sms_pkg::ROW_BITS;

    // Configuration registers
    logic [RW-1:0] r_start_row;
    logic [RW-1:0] r_end_row;

    // Item and scan state
    sms_pkg::t_mode r_mode;
    logic [RW-1:0]  r_row;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_ptr;
    logic           r_rd_valid;
    logic [AW-1:0]  r_rd_idx;
    logic           r_found;
    logic [AW-1:0]  r_found_idx;
    logic           r_best_valid;
    logic [RW-1:0]  r_best;
    logic [RW-1:0]  r_last;

    // Result registers
    logic           r_strobe;
    logic           r_is_marked;
    logic [RW-1:0]  r_mark_row;
    logic           r_res_status;

    logic [RW-1:0]  rd_data;
    logic           issue;
    logic           hit_eq;
    logic           hit_gt;
    logic           hit_lt;
    logic           take_next;
    logic           take_prev;
    logic           is_last;
    logic           row_nz;
    logic           full;
    logic           is_toggle;
    logic           do_remove;
    logic           do_insert;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [RW-1:0]  ram_wdata;
    logic [RW-1:0]  n_mark_row;

    // Store of marks; only the first r_count entries hold marks, in any order
    sms_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_MARKS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Scan compares on the entry just read
    assign issue     = i_cmd.scan && (r_ptr < r_count);
    assign hit_eq    = (rd_data == r_row);
    assign hit_gt    = (rd_data > r_row);
    assign hit_lt    = (rd_data < r_row);
    assign take_next = (r_mode == sms_pkg::MODE_NEXT) && hit_gt
                       && (!r_best_valid || (rd_data < r_best));
    assign take_prev = (r_mode == sms_pkg::MODE_PREV) && hit_lt
                       && (!r_best_valid || (rd_data > r_best));
    assign is_last   = (CW'(r_rd_idx) == (r_count - CW'(1)));

    assign o_status.scan_done = (r_ptr >= r_count) && !r_rd_valid;

    // Toggle decision at the end of the scan
    assign row_nz    = (r_row != '0);
    assign full      = (r_count >= CW'(MAX_MARKS));
    assign is_toggle = (r_mode == sms_pkg::MODE_TOGGLE);
    assign do_remove = i_cmd.finish && is_toggle && row_nz && r_found;
    assign do_insert = i_cmd.finish && is_toggle && row_nz && !r_found && !full;

    // Removal moves the last mark into the freed slot; insertion appends
    assign ram_we    = do_remove || do_insert;
    assign ram_waddr = do_remove ? r_found_idx : r_count[AW-1:0];
    assign ram_wdata = do_remove ? r_last : r_row;

    // Mark row of the result
    always_comb begin
        unique case (r_mode)
            sms_pkg::MODE_NEXT: n_mark_row = r_best_valid ? r_best : r_end_row;
            sms_pkg::MODE_PREV: n_mark_row = r_best_valid ? r_best : r_start_row;
            default:            n_mark_row = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_row <= sms_pkg::START_ROW_RST;
            r_end_row   <= sms_pkg::END_ROW_RST;
            r_count     <= '0;
            r_ptr       <= '0;
            r_rd_valid  <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sms_pkg::REG_START_ROW: r_start_row <= i_cfg_data;
                    sms_pkg::REG_END_ROW:   r_end_row   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_ptr <= '0;
            end else if (issue) begin
                r_ptr <= r_ptr + CW'(1);
            end
            r_rd_valid <= issue;
            if (do_remove) begin
                r_count <= r_count - CW'(1);
            end else if (do_insert) begin
                r_count <= r_count + CW'(1);
            end
            r_strobe <= i_cmd.finish;
        end
    end

    // Item and scan payload
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_ptr[AW-1:0];
        if (i_cmd.load) begin
            r_mode       <= sms_pkg::t_mode'(i_mode);
            r_row        <= i_row;
            r_found      <= 1'b0;
            r_best_valid <= 1'b0;
        end else if (r_rd_valid) begin
            if (hit_eq) begin
                r_found     <= 1'b1;
                r_found_idx <= r_rd_idx;
            end
            if (take_next || take_prev) begin
                r_best_valid <= 1'b1;
                r_best       <= rd_data;
            end
            if (is_last) begin
                r_last <= rd_data;
            end
        end
    end

    // Result registers, loaded when the item finishes
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_is_marked  <= is_toggle ? (row_nz && !r_found && !full) : r_found;
            r_mark_row   <= n_mark_row;
            r_res_status <= is_toggle && row_nz && !r_found && full;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_is_marked     = r_is_marked;
    assign o_mark_row      = r_mark_row;
    assign o_result_status = r_res_status;

    // The fill count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_MARKS))
        else $error("mark count above capacity");

    // An accepted insertion grows the set by one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    // An accepted removal shrinks the set by one
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_remove |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink the count");

    // A refused insertion never reports the row as marked
    a_full_unmarked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res_status) |-> !r_is_marked)
        else $error("refused insert reported as marked");

endmodule

`default_nettype wire

### design/sorted_mark_set_core.sv
// Sorted mark set core: toggle, membership, next and previous mark queries.
//
// Keeps up to MAX_MARKS nonzero row numbers. An item is taken when start is
// high and busy is low; its result appears on the o_ ports for one cycle with
// o_strobe high and must be taken then, as there is no back-pressure. Every
// item walks the stored marks through the store's single read port, one entry
// a cycle, so the scan sets the time per item. Busy stays high through the
// scan and finish states. The result strobe comes in the first cycle with
// busy low, and the next item may be taken at the end of that cycle. No
// clearing pass is needed after reset. The configuration port is always
// ready; write it only while the block is idle.
`default_nettype none

module sorted_mark_set_core #(
    parameter int MAX_MARKS = sms_pkg::MAX_MARKS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic [1:0]                        i_mode,
    input  wire logic [sms_pkg::ROW_BITS-1:0]      i_row,
    output      logic                              o_strobe,
    output      logic                              o_is_marked,
    output      logic [sms_pkg::ROW_BITS-1:0]      o_mark_row,
    output      logic                              o_status,
    input  wire logic                              i_cfg_valid,
    output      logic                              o_cfg_ready,
    input  wire logic [sms_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [sms_pkg::ROW_BITS-1:0]      i_cfg_data
);

    sms_pkg::t_ctrl_cmd    cmd;
    sms_pkg::t_ctrl_status status;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    sms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_cmd    (cmd),
        .i_status (status)
    );

    // Store, scan and results
    sms_datapath #(
        .MAX_MARKS (MAX_MARKS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_mode          (i_mode),
        .i_row           (i_row),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_is_marked     (o_is_marked),
        .o_mark_row      (o_mark_row),
        .o_result_status (o_status)
    );

endmodule

`default_nettype wire
